// File: sv/ppsu_pkg.sv
// ----------------------------------------------------------------------------
// ppsu_pkg: shared types and constants of the priority scheduler
// Opcodes, field widths, time limit and the control bundle sent to the
// slot table.
// ----------------------------------------------------------------------------
package ppsu_pkg;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned ID_W    = 16;
  localparam int unsigned ARR_W   = 16;
  localparam int unsigned BURST_W = 16;
  localparam int unsigned PRIO_W  = 8;
  localparam int unsigned TIME_W  = 22;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // Item operations
  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_TICK  = 2'd2
  } opcode_t;

  // Per-item table update, valid only in the cycle the item is processed
  typedef struct packed {
    logic clear;
    logic load;
    logic serve;
    logic finish;
  } tbl_ctl_t;

endpackage

// File: sv/ppsu_arbiter.sv
// ----------------------------------------------------------------------------
// ppsu_arbiter: priority pick over the task slots
// Binary compare tree: highest priority wins, then earlier arrival, then
// lower slot.
// ----------------------------------------------------------------------------
module ppsu_arbiter
  import ppsu_pkg::*;
#(
  parameter int unsigned SLOTS = 16
) (
  input  logic [SLOTS-1:0]         elig,
  input  logic [PRIO_W-1:0]        prio    [SLOTS],
  input  logic [ARR_W-1:0]         arrival [SLOTS],
  output logic                     found,
  output logic [$clog2(SLOTS)-1:0] win_idx
);

  localparam int unsigned IDX_W  = $clog2(SLOTS);
  localparam int unsigned NLEAF  = 1 << IDX_W;
  localparam int unsigned NNODE  = 2 * NLEAF - 1;

  logic              n_vld  [NNODE];
  logic [PRIO_W-1:0] n_prio [NNODE];
  logic [ARR_W-1:0]  n_arr  [NNODE];
  logic [IDX_W-1:0]  n_idx  [NNODE];

  // Leaves, padded up to a power of two with empty entries
  for (genvar i = 0; i < NLEAF; i++) begin : g_leaf
    if (i < SLOTS) begin : g_used
      assign n_vld[NLEAF-1+i]  = elig[i];
      assign n_prio[NLEAF-1+i] = prio[i];
      assign n_arr[NLEAF-1+i]  = arrival[i];
    end else begin : g_pad
      assign n_vld[NLEAF-1+i]  = 1'b0;
      assign n_prio[NLEAF-1+i] = '0;
      assign n_arr[NLEAF-1+i]  = '0;
    end
    assign n_idx[NLEAF-1+i] = IDX_W'(i);
  end

  // Inner nodes: left child holds the lower slots and keeps full ties
  for (genvar n = 0; n < NLEAF - 1; n++) begin : g_node
    logic take_hi;
    assign take_hi = n_vld[2*n+2] &&
                     (!n_vld[2*n+1] ||
                      (n_prio[2*n+2] > n_prio[2*n+1]) ||
                      ((n_prio[2*n+2] == n_prio[2*n+1]) &&
                       (n_arr[2*n+2] < n_arr[2*n+1])));
    assign n_vld[n]  = n_vld[2*n+1] | n_vld[2*n+2];
    assign n_prio[n] = take_hi ? n_prio[2*n+2] : n_prio[2*n+1];
    assign n_arr[n]  = take_hi ? n_arr[2*n+2]  : n_arr[2*n+1];
    assign n_idx[n]  = take_hi ? n_idx[2*n+2]  : n_idx[2*n+1];
  end

  assign found   = n_vld[0];
  assign win_idx = n_idx[0];

endmodule

// File: sv/ppsu_slot_table.sv
// ----------------------------------------------------------------------------
// ppsu_slot_table: task slot storage
// Holds per-slot task data and status, flags slots ready to run and reads
// out the served slot.
// ----------------------------------------------------------------------------
module ppsu_slot_table
  import ppsu_pkg::*;
#(
  parameter int unsigned SLOTS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  tbl_ctl_t                 ctl,
  input  logic [SLOT_W-1:0]        ld_slot,
  input  logic [ID_W-1:0]          ld_id,
  input  logic [ARR_W-1:0]         ld_arrival,
  input  logic [BURST_W-1:0]       ld_burst,
  input  logic [PRIO_W-1:0]        ld_prio,
  input  logic [TIME_W-1:0]        cur_time,
  input  logic [$clog2(SLOTS)-1:0] sel_idx,
  output logic [SLOTS-1:0]         elig,
  output logic [PRIO_W-1:0]        prio    [SLOTS],
  output logic [ARR_W-1:0]         arrival [SLOTS],
  output logic [ID_W-1:0]          sel_id,
  output logic [ARR_W-1:0]         sel_arrival,
  output logic [BURST_W-1:0]       sel_burst,
  output logic [BURST_W-1:0]       sel_rem,
  output logic                     all_done_nxt
);

  localparam int unsigned IDX_W = $clog2(SLOTS);

  logic [SLOTS-1:0]   loaded_r, loaded_nxt;
  logic [SLOTS-1:0]   done_r, done_nxt;
  logic [ID_W-1:0]    id_r    [SLOTS];
  logic [ARR_W-1:0]   arr_r   [SLOTS];
  logic [BURST_W-1:0] burst_r [SLOTS];
  logic [BURST_W-1:0] rem_r   [SLOTS];
  logic [PRIO_W-1:0]  prio_r  [SLOTS];
  logic [SLOTS-1:0]   ld_hit;
  logic [SLOTS-1:0]   sv_hit;

  for (genvar i = 0; i < SLOTS; i++) begin : g_slot
    // Decode the write targets; a load beyond the table hits nothing
    assign ld_hit[i] = ctl.load && ({28'd0, ld_slot} == 32'(i));
    assign sv_hit[i] = ctl.serve && (sel_idx == IDX_W'(i));

    // Status next state
    always_comb begin
      loaded_nxt[i] = loaded_r[i];
      done_nxt[i]   = done_r[i];
      if (ctl.clear) begin
        loaded_nxt[i] = 1'b0;
        done_nxt[i]   = 1'b0;
      end else if (ld_hit[i]) begin
        loaded_nxt[i] = 1'b1;
        done_nxt[i]   = 1'b0;
      end else if (sv_hit[i] && ctl.finish) begin
        done_nxt[i]   = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        loaded_r[i] <= 1'b0;
        done_r[i]   <= 1'b0;
      end else begin
        loaded_r[i] <= loaded_nxt[i];
        done_r[i]   <= done_nxt[i];
      end
    end

    // Task data: written by a load, remaining time counted down on service
    always_ff @(posedge clk) begin
      if (ld_hit[i]) begin
        id_r[i]    <= ld_id;
        arr_r[i]   <= ld_arrival;
        burst_r[i] <= ld_burst;
        rem_r[i]   <= ld_burst;
        prio_r[i]  <= ld_prio;
      end else if (sv_hit[i]) begin
        rem_r[i] <= ctl.finish ? '0 : rem_r[i] - BURST_W'(1);
      end
    end

    // Ready to run: loaded, unfinished and already arrived
    assign elig[i]    = loaded_r[i] && !done_r[i] &&
                        ({{(TIME_W-ARR_W){1'b0}}, arr_r[i]} <= cur_time);
    assign prio[i]    = prio_r[i];
    assign arrival[i] = arr_r[i];
  end

  // Read out the served slot
  assign sel_id      = id_r[sel_idx];
  assign sel_arrival = arr_r[sel_idx];
  assign sel_burst   = burst_r[sel_idx];
  assign sel_rem     = rem_r[sel_idx];

  assign all_done_nxt = ~|(loaded_nxt & ~done_nxt);

endmodule

// File: sv/preemptive_priority_scheduler_unit.sv
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_unit: preemptive priority task scheduler
// Loads task slots and, on each tick item, serves the best ready task and
// reports its completion figures.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-------------------------------
//   in_     | input     | in_valid/in_ready   | opcode, slot, id, arrival,
//           |           |                     | burst, prio
//   out_    | output    | out_valid/out_ready | ran, served slot/id, finished,
//           |           |                     | times, now, all_done
//
// One item per cycle sustained while out_ready holds; an item's result passes
// from the input register through the arbiter tree and table update into the
// result register, where it is held until out_ready takes it.
// The slot arbiter tree sets the cycle time.
// Reset clears slot status and time; slot data is undefined until loaded.
// A stalled result register holds the item in the input register, and
// in_ready drops only when both stages are full.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_unit
  import ppsu_pkg::*;
#(
  parameter int unsigned SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [OP_W-1:0]    in_opcode,
  input  logic [SLOT_W-1:0]  in_slot,
  input  logic [ID_W-1:0]    in_task_id,
  input  logic [ARR_W-1:0]   in_arrival,
  input  logic [BURST_W-1:0] in_burst,
  input  logic [PRIO_W-1:0]  in_prio,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_ran,
  output logic [SLOT_W-1:0]  out_served_slot,
  output logic [ID_W-1:0]    out_served_id,
  output logic               out_finished,
  output logic [TIME_W-1:0]  out_completion_time,
  output logic [TIME_W-1:0]  out_turnaround,
  output logic [TIME_W-1:0]  out_wait_time,
  output logic [TIME_W-1:0]  out_now,
  output logic               out_all_done
);

  localparam int unsigned IDX_W = $clog2(SLOTS);

  // Input register
  logic               s_valid_r;
  logic [OP_W-1:0]    s_opcode_r;
  logic [SLOT_W-1:0]  s_slot_r;
  logic [ID_W-1:0]    s_id_r;
  logic [ARR_W-1:0]   s_arr_r;
  logic [BURST_W-1:0] s_burst_r;
  logic [PRIO_W-1:0]  s_prio_r;

  // Time and result register
  logic [TIME_W-1:0]  time_r, time_nxt, time_inc;
  logic               out_valid_r;
  logic               ran_r;
  logic [SLOT_W-1:0]  sslot_r;
  logic [ID_W-1:0]    sid_r;
  logic               fin_r;
  logic [TIME_W-1:0]  comp_r, tat_r, wt_r, now_r;
  logic               all_done_r;

  logic               advance;
  logic               is_clear, is_load, is_tick;
  tbl_ctl_t           ctl;
  logic [SLOTS-1:0]   elig;
  logic [PRIO_W-1:0]  prio    [SLOTS];
  logic [ARR_W-1:0]   arrival [SLOTS];
  logic               found;
  logic [IDX_W-1:0]   win_idx;
  logic [IDX_W+3:0]   win_ext;
  logic [ID_W-1:0]    sel_id;
  logic [ARR_W-1:0]   sel_arrival;
  logic [BURST_W-1:0] sel_burst;
  logic [BURST_W-1:0] sel_rem;
  logic               all_done_nxt;
  logic               serve, finish;
  logic [TIME_W-1:0]  tat, burst_ext;

  // Handshake: the input register moves on whenever the result slot frees
  assign advance  = s_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_ready) begin
      s_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s_opcode_r <= in_opcode;
      s_slot_r   <= in_slot;
      s_id_r     <= in_task_id;
      s_arr_r    <= in_arrival;
      s_burst_r  <= in_burst;
      s_prio_r   <= in_prio;
    end
  end

  // Decode the held item
  always_comb begin
    is_clear = 1'b0;
    is_load  = 1'b0;
    is_tick  = 1'b0;
    unique case (s_opcode_r)
      OP_CLEAR: is_clear = 1'b1;
      OP_LOAD:  is_load  = 1'b1;
      OP_TICK:  is_tick  = 1'b1;
      default:  ;
    endcase
  end

  ppsu_slot_table #(
    .SLOTS (SLOTS)
  ) u_table (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .ld_slot      (s_slot_r),
    .ld_id        (s_id_r),
    .ld_arrival   (s_arr_r),
    .ld_burst     (s_burst_r),
    .ld_prio      (s_prio_r),
    .cur_time     (time_r),
    .sel_idx      (win_idx),
    .elig         (elig),
    .prio         (prio),
    .arrival      (arrival),
    .sel_id       (sel_id),
    .sel_arrival  (sel_arrival),
    .sel_burst    (sel_burst),
    .sel_rem      (sel_rem),
    .all_done_nxt (all_done_nxt)
  );

  ppsu_arbiter #(
    .SLOTS (SLOTS)
  ) u_arb (
    .elig    (elig),
    .prio    (prio),
    .arrival (arrival),
    .found   (found),
    .win_idx (win_idx)
  );

  // Serve the winner; it finishes when at most one tick remains
  assign serve  = advance && is_tick && found;
  assign finish = serve && (sel_rem <= BURST_W'(1));

  always_comb begin
    ctl.clear  = advance && is_clear;
    ctl.load   = advance && is_load;
    ctl.serve  = serve;
    ctl.finish = finish;
  end

  // Saturating time step
  assign time_inc = (time_r == TIME_MAX) ? time_r : time_r + TIME_W'(1);

  always_comb begin
    time_nxt = time_r;
    if (is_clear) begin
      time_nxt = '0;
    end else if (is_tick) begin
      time_nxt = time_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r <= '0;
    end else if (advance) begin
      time_r <= time_nxt;
    end
  end

  // Completion figures; waiting time floors at zero
  assign tat       = time_inc - {{(TIME_W-ARR_W){1'b0}}, sel_arrival};
  assign burst_ext = {{(TIME_W-BURST_W){1'b0}}, sel_burst};
  assign win_ext   = {{4{1'b0}}, win_idx};

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ran_r      <= serve;
      sslot_r    <= serve ? win_ext[SLOT_W-1:0] : '0;
      sid_r      <= serve ? sel_id : '0;
      fin_r      <= finish;
      comp_r     <= finish ? time_inc : '0;
      tat_r      <= finish ? tat : '0;
      wt_r       <= (finish && (tat > burst_ext)) ? tat - burst_ext : '0;
      now_r      <= time_nxt;
      all_done_r <= all_done_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_ran             = ran_r;
  assign out_served_slot     = sslot_r;
  assign out_served_id       = sid_r;
  assign out_finished        = fin_r;
  assign out_completion_time = comp_r;
  assign out_turnaround      = tat_r;
  assign out_wait_time       = wt_r;
  assign out_now             = now_r;
  assign out_all_done        = all_done_r;

endmodule

// File: bench/preemptive_priority_scheduler_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_unit_test: self-checking bench for the scheduler
// Drives clear, load and tick items through the valid/ready input channel,
// predicts every result from a local copy of the slot table and compares it
// with the result channel. It runs in phases of sender gaps and receiver
// stalls.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_unit_test
  import ppsu_pkg::*;
();

  localparam int SLOTS       = 16;
  localparam int N_ITEMS     = 1100;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;

  // Opcode that the block ignores
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [SLOT_W-1:0]  slot;
    logic [ID_W-1:0]    id;
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
    logic [1:0]         phase;
  } task_item_t;

  typedef struct packed {
    logic               ran;
    logic [SLOT_W-1:0]  slot;
    logic [ID_W-1:0]    id;
    logic               finished;
    logic [TIME_W-1:0]  completion;
    logic [TIME_W-1:0]  turnaround;
    logic [TIME_W-1:0]  wait_time;
    logic [TIME_W-1:0]  now;
    logic               all_done;
  } tick_report_t;

  logic clk;
  logic rst_n = 1'b0;

  logic               in_valid   = 1'b0;
  logic               in_ready;
  logic [OP_W-1:0]    in_opcode  = '0;
  logic [SLOT_W-1:0]  in_slot    = '0;
  logic [ID_W-1:0]    in_task_id = '0;
  logic [ARR_W-1:0]   in_arrival = '0;
  logic [BURST_W-1:0] in_burst   = '0;
  logic [PRIO_W-1:0]  in_prio    = '0;
  logic               out_valid;
  logic               out_ready  = 1'b0;
  logic               out_ran;
  logic [SLOT_W-1:0]  out_served_slot;
  logic [ID_W-1:0]    out_served_id;
  logic               out_finished;
  logic [TIME_W-1:0]  out_completion_time;
  logic [TIME_W-1:0]  out_turnaround;
  logic [TIME_W-1:0]  out_wait_time;
  logic [TIME_W-1:0]  out_now;
  logic               out_all_done;

  // Stimulus and expectations
  task_item_t   task_items[$];
  tick_report_t tick_reports[$];
  task_item_t   cur_item;
  logic [1:0]   rx_phase = 2'd0;

  // Local copy of the slot table
  logic [SLOTS-1:0]   tbl_loaded;
  logic [SLOTS-1:0]   tbl_done;
  logic [ID_W-1:0]    tbl_id[SLOTS];
  logic [ARR_W-1:0]   tbl_arrival[SLOTS];
  logic [BURST_W-1:0] tbl_burst[SLOTS];
  logic [BURST_W-1:0] tbl_left[SLOTS];
  logic [PRIO_W-1:0]  tbl_prio[SLOTS];
  logic [TIME_W-1:0]  sched_time;

  int n_sent     = 0;
  int n_checked  = 0;
  int n_ticks    = 0;
  int n_finished = 0;
  int n_errors   = 0;
  int cycle_count = 0;

  preemptive_priority_scheduler_unit #(
    .SLOTS(SLOTS)
  ) uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_slot            (in_slot),
    .in_task_id         (in_task_id),
    .in_arrival         (in_arrival),
    .in_burst           (in_burst),
    .in_prio            (in_prio),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_ran            (out_ran),
    .out_served_slot    (out_served_slot),
    .out_served_id      (out_served_id),
    .out_finished       (out_finished),
    .out_completion_time(out_completion_time),
    .out_turnaround     (out_turnaround),
    .out_wait_time      (out_wait_time),
    .out_now            (out_now),
    .out_all_done       (out_all_done)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [TIME_W-1:0] next_time(input logic [TIME_W-1:0] t);
    return (t == TIME_MAX) ? t : t + 1'b1;
  endfunction

  // Queue one item; its place in the run sets its idling phase
  task automatic add_item(input logic [OP_W-1:0] op, input int slot, input int id,
                          input int arrival, input int burst, input int prio);
    task_item_t it;
    int ph;
    ph = (task_items.size() * 4) / N_ITEMS;
    if (ph > 3) ph = 3;
    it.opcode  = op;
    it.slot    = SLOT_W'(slot);
    it.id      = ID_W'(id);
    it.arrival = ARR_W'(arrival);
    it.burst   = BURST_W'(burst);
    it.prio    = PRIO_W'(prio);
    it.phase   = 2'(ph);
    task_items.push_back(it);
  endtask

  // Apply one accepted item to the table copy and queue the report it gives
  task automatic schedule_item(input task_item_t it);
    tick_report_t r;
    int best;
    logic [TIME_W-1:0] done_at;
    logic [TIME_W-1:0] tat;
    r = '0;
    best = -1;
    case (it.opcode)
      OP_CLEAR: begin
        tbl_loaded = '0;
        tbl_done   = '0;
        sched_time = '0;
      end
      OP_LOAD: begin
        tbl_loaded[it.slot]  = 1'b1;
        tbl_done[it.slot]    = 1'b0;
        tbl_id[it.slot]      = it.id;
        tbl_arrival[it.slot] = it.arrival;
        tbl_burst[it.slot]   = it.burst;
        tbl_left[it.slot]    = it.burst;
        tbl_prio[it.slot]    = it.prio;
      end
      OP_TICK: begin
        n_ticks++;
        // Pick the highest priority ready task; ties to earlier arrival, then lower slot
        for (int i = 0; i < SLOTS; i++) begin
          if (tbl_loaded[i] && !tbl_done[i] && TIME_W'(tbl_arrival[i]) <= sched_time) begin
            if (best < 0 || tbl_prio[i] > tbl_prio[best] ||
                (tbl_prio[i] == tbl_prio[best] && tbl_arrival[i] < tbl_arrival[best]))
              best = i;
          end
        end
        if (best >= 0) begin
          r.ran  = 1'b1;
          r.slot = SLOT_W'(best);
          r.id   = tbl_id[best];
          if (tbl_left[best] <= 1) begin
            done_at         = next_time(sched_time);
            tat             = done_at - TIME_W'(tbl_arrival[best]);
            tbl_left[best]  = '0;
            tbl_done[best]  = 1'b1;
            r.finished      = 1'b1;
            r.completion    = done_at;
            r.turnaround    = tat;
            r.wait_time     = (tat > TIME_W'(tbl_burst[best])) ?
                              tat - TIME_W'(tbl_burst[best]) : '0;
            n_finished++;
          end else begin
            tbl_left[best] = tbl_left[best] - 1'b1;
          end
        end
        sched_time = next_time(sched_time);
      end
      default: ;
    endcase
    r.now      = sched_time;
    r.all_done = ((tbl_loaded & ~tbl_done) == '0);
    tick_reports.push_back(r);
  endtask

  // Driver: present the next item once the current one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        schedule_item(cur_item);
        n_sent++;
      end
      if (!in_valid || in_ready) begin
        if (task_items.size() > 0 &&
            $urandom_range(99) >= ((task_items[0].phase == 2'd1) ? 47 :
                                   (task_items[0].phase == 2'd3) ? 26 : 0)) begin
          cur_item   = task_items.pop_front();
          in_valid   <= 1'b1;
          in_opcode  <= cur_item.opcode;
          in_slot    <= cur_item.slot;
          in_task_id <= cur_item.id;
          in_arrival <= cur_item.arrival;
          in_burst   <= cur_item.burst;
          in_prio    <= cur_item.prio;
          rx_phase   <= cur_item.phase;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result against the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (tick_reports.size() == 0) begin
          if (n_errors < MAX_REPORTS)
            $display("ERROR: result with nothing expected (ran=%0d now=%0d)",
                     out_ran, out_now);
          n_errors++;
        end else begin
          tick_report_t e;
          e = tick_reports.pop_front();
          n_checked++;
          if (out_ran !== e.ran || out_served_slot !== e.slot ||
              out_served_id !== e.id || out_finished !== e.finished ||
              out_completion_time !== e.completion || out_turnaround !== e.turnaround ||
              out_wait_time !== e.wait_time || out_now !== e.now ||
              out_all_done !== e.all_done) begin
            if (n_errors < MAX_REPORTS) begin
              $display("ERROR: result %0d expected ran=%0d slot=%0d id=%h fin=%0d",
                       n_checked, e.ran, e.slot, e.id, e.finished);
              $display("       comp=%0d tat=%0d wait=%0d now=%0d all_done=%0d",
                       e.completion, e.turnaround, e.wait_time, e.now, e.all_done);
              $display("       got      ran=%0d slot=%0d id=%h fin=%0d",
                       out_ran, out_served_slot, out_served_id, out_finished);
              $display("       comp=%0d tat=%0d wait=%0d now=%0d all_done=%0d",
                       out_completion_time, out_turnaround, out_wait_time, out_now,
                       out_all_done);
            end
            n_errors++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= ((rx_phase == 2'd2) ? 47 :
                                           (rx_phase == 2'd3) ? 26 : 0));
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout: %0d items sent, %0d results outstanding", n_sent,
               tick_reports.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int n_tasks;
    int max_arr;
    int total_burst;
    int n_steps;
    int arr;
    int bst;
    tbl_loaded = '0;
    tbl_done   = '0;
    sched_time = '0;

    // Directed: empty table, ignored opcode, field extremes, ties, zero burst,
    // reload of a busy slot and preemption by a later arrival
    add_item(OP_TICK,  0, 0, 0, 1, 0);
    add_item(OP_SPARE, 15, 'hFFFF, 'hFFFF, 'hFFFF, 'hFF);
    add_item(OP_CLEAR, 0, 0, 0, 1, 0);
    add_item(OP_LOAD,  0, 'hFFFF, 0, 1, 'hFF);
    add_item(OP_LOAD,  15, 0, 'hFFFF, 'hFFFF, 0);
    add_item(OP_LOAD,  3, 'h1234, 0, 0, 10);
    add_item(OP_LOAD,  5, 'h5555, 1, 2, 80);
    add_item(OP_LOAD,  2, 'h2222, 1, 2, 80);
    add_item(OP_LOAD,  9, 'h9999, 0, 3, 80);
    add_item(OP_TICK,  0, 0, 0, 1, 0);
    add_item(OP_TICK,  0, 0, 0, 1, 0);
    add_item(OP_TICK,  0, 0, 0, 1, 0);
    add_item(OP_LOAD,  9, 'hAAAA, 2, 1, 80);
    for (int k = 0; k < 7; k++) add_item(OP_TICK, 0, 0, 0, 1, 0);
    add_item(OP_LOAD,  6, 'h8001, 3, 1, 'hC0);
    for (int k = 0; k < 3; k++) add_item(OP_TICK, 0, 0, 0, 1, 0);
    add_item(OP_CLEAR, 0, 0, 0, 1, 0);

    // Random sessions: mostly a clear, load 1 to 16 tasks, tick until the short ones drain
    while (task_items.size() < N_ITEMS) begin
      if ($urandom_range(9) != 0) add_item(OP_CLEAR, 0, 0, 0, 1, 0);
      n_tasks = ($urandom_range(3) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 5);
      max_arr = 0;
      total_burst = 0;
      for (int k = 0; k < n_tasks; k++) begin
        arr = ($urandom_range(19) == 0) ? $urandom_range(65535) : $urandom_range(12);
        bst = ($urandom_range(19) == 0) ? $urandom_range(65535) :
              ($urandom_range(29) == 0) ? 0 : $urandom_range(1, 6);
        if (arr <= 12 && arr > max_arr) max_arr = arr;
        if (bst <= 6) total_burst += bst;
        add_item(OP_LOAD, $urandom_range(15), $urandom_range(65535), arr, bst,
                 ($urandom_range(2) == 0) ? $urandom_range(255) : $urandom_range(3));
      end
      n_steps = max_arr + total_burst + $urandom_range(3);
      for (int k = 0; k < n_steps; k++) begin
        case ($urandom_range(29))
          0, 1: begin
            // Late arrival that may preempt the running task
            bst = $urandom_range(1, 4);
            add_item(OP_LOAD, $urandom_range(15), $urandom_range(65535),
                     $urandom_range(max_arr + k + 2), bst, $urandom_range(255));
            n_steps += bst;
          end
          2: add_item(OP_SPARE, $urandom_range(15), $urandom_range(65535),
                      $urandom_range(65535), $urandom_range(65535), $urandom_range(255));
          default: ;
        endcase
        add_item(OP_TICK, $urandom_range(15), $urandom_range(65535),
                 $urandom_range(65535), $urandom_range(65535), $urandom_range(255));
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Drain, then allow the pipeline to settle
    do @(negedge clk);
    while (task_items.size() != 0 || in_valid || tick_reports.size() != 0);
    repeat (8) @(posedge clk);

    $display("Sent %0d items (%0d ticks), checked %0d results, %0d tasks finished",
             n_sent, n_ticks, n_checked, n_finished);
    $display("Idling phases: none, sender gaps, receiver stalls, both; %0d mismatches",
             n_errors);
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
